// ===== hw/rtl/rrd_pkg.sv =====
// Shared constants and types for the repetition reach distribution block.
// No dependencies; imported by the engine, the top level and the checker.
package rrd_pkg;

    // Q1.16 probability format
    localparam int unsigned PROB_W = 17;
    localparam logic [PROB_W-1:0] PROB_ONE = 17'h10000;
    localparam logic [PROB_W-1:0] PROB_ZERO = 17'h00000;

    // default configuration
    localparam int unsigned DEF_MAX_CLASSES = 64;
    localparam int unsigned DEF_COUNT_FRAC_BITS = 8;

    // result strobe and flags from the engine to the output register
    typedef struct packed {
        logic load;
        logic is_empty;
        logic last;
    } res_ctl_t;

endpackage

// ===== hw/rtl/rrd_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module rrd_ram #(
    parameter int unsigned WIDTH = 17,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write, and registered read that returns the old contents
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rrd_engine.sv =====
// Sequencer and update datapath: runs the backward passes over the class table
// through the RAM port, then reads the table out; n <= 1 gives one direct word. Depends on rrd_pkg.
module rrd_engine #(
    parameter int unsigned MAX_CLASSES     = rrd_pkg::DEF_MAX_CLASSES,
    parameter int unsigned COUNT_FRAC_BITS = rrd_pkg::DEF_COUNT_FRAC_BITS
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // input word
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic [rrd_pkg::PROB_W-1:0]               trial_prob,
    input  logic [$clog2(MAX_CLASSES)+COUNT_FRAC_BITS:0] trial_count,
    // result to the output register
    input  logic                                     out_free,
    output rrd_pkg::res_ctl_t                        res_ctl,
    output logic [$clog2(MAX_CLASSES)-1:0]           res_index,
    output logic [rrd_pkg::PROB_W-1:0]               res_prob,
    output logic [$clog2(MAX_CLASSES+1)-1:0]         res_total,
    // class table RAM
    output logic                                     ram_we,
    output logic [$clog2(MAX_CLASSES)-1:0]           ram_waddr,
    output logic [rrd_pkg::PROB_W-1:0]               ram_wdata,
    output logic                                     ram_re,
    output logic [$clog2(MAX_CLASSES)-1:0]           ram_raddr,
    input  logic [rrd_pkg::PROB_W-1:0]               ram_rdata
);

    import rrd_pkg::*;

    localparam int unsigned F  = COUNT_FRAC_BITS;
    localparam int unsigned AW = $clog2(MAX_CLASSES);
    localparam int unsigned TW = $clog2(MAX_CLASSES + 1);
    localparam int unsigned CW = AW + 1 + F;
    localparam int unsigned MW = PROB_W + F + 1;
    localparam logic [CW-1:0] COUNT_LIMIT = CW'(MAX_CLASSES * (2 ** COUNT_FRAC_BITS));
    localparam logic [CW-1:0] COUNT_ONE   = CW'(2 ** COUNT_FRAC_BITS);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SETUP = 7'b0000010,
        ST_EX    = 7'b0000100,
        ST_WB    = 7'b0001000,
        ST_ORD   = 7'b0010000,
        ST_OSH   = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [PROB_W-1:0]  p_reg, p_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [MW-1:0]      mul_reg, mul_next;
    logic [TW-1:0]      total_reg, total_next;
    logic [PROB_W-1:0]  factor_reg, factor_next;
    logic [AW-1:0]      top_reg, top_next;
    logic [AW-1:0]      k_reg, k_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [PROB_W-1:0]  cur_reg, cur_next;
    logic [PROB_W-1:0]  nb_reg, nb_next;
    logic [PROB_W-1:0]  prod_reg, prod_next;
    logic               cond_reg, cond_next;
    logic               frac_pass_reg, frac_pass_next;
    logic               fwd_reg, fwd_next;
    logic [PROB_W-1:0]  fwd_data_reg, fwd_data_next;

    logic [AW:0]        whole;
    logic [F-1:0]       frac;
    logic [F:0]         mul_op;
    logic [PROB_W-1:0]  nb;
    logic [PROB_W-1:0]  diff;
    logic [2*PROB_W-1:0] prod_full;
    logic [PROB_W:0]    sum;
    logic [PROB_W-1:0]  wval;
    logic               last_out;

    assign whole = n_reg[CW-1:F];
    assign frac  = n_reg[F-1:0];

    // small multiplier: p times the count (single entry) or its fraction
    assign mul_op = (n_reg <= COUNT_ONE) ? n_reg[F:0] : {1'b0, frac};

    // neighbor value: 1.0 for class 0, else RAM data or the value just written
    assign nb = (k_reg == '0) ? PROB_ONE : (fwd_reg ? fwd_data_reg : ram_rdata);
    assign diff = nb - cur_reg;
    assign prod_full = (2*PROB_W)'(diff) * (2*PROB_W)'(factor_reg);

    // raise and clamp to 1.0
    assign sum  = {1'b0, cur_reg} + {1'b0, prod_reg};
    assign wval = cond_reg ? ((sum > {1'b0, PROB_ONE}) ? PROB_ONE : sum[PROB_W-1:0])
                           : cur_reg;

    assign last_out = ((TW'(idx_reg) + TW'(1)) == total_reg);
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        p_next         = p_reg;
        n_next         = n_reg;
        mul_next       = mul_reg;
        total_next     = total_reg;
        factor_next    = factor_reg;
        top_next       = top_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        nb_next        = nb_reg;
        prod_next      = prod_reg;
        cond_next      = cond_reg;
        frac_pass_next = frac_pass_reg;
        fwd_next       = fwd_reg;
        fwd_data_next  = fwd_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = k_reg;
        ram_wdata      = wval;
        ram_re         = 1'b0;
        ram_raddr      = idx_reg;
        res_ctl        = '0;
        res_index      = idx_reg;
        res_prob       = ram_rdata;
        res_total      = total_reg;

        case (state_reg)
            ST_IDLE:
            begin
                // saturate probability and count on capture
                if (in_valid)
                begin
                    p_next = (trial_prob > PROB_ONE) ? PROB_ONE : trial_prob;
                    n_next = (trial_count > COUNT_LIMIT) ? COUNT_LIMIT : trial_count;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                mul_next   = MW'(p_reg) * MW'(mul_op);
                total_next = TW'(whole) + TW'(frac != '0);
                if (n_reg <= COUNT_ONE)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    // first pass: top 0, nothing to read
                    top_next       = '0;
                    k_next         = '0;
                    cur_next       = PROB_ZERO;
                    factor_next    = p_reg;
                    frac_pass_next = 1'b0;
                    fwd_next       = 1'b0;
                    state_next     = ST_EX;
                end
            end
            ST_EX:
            begin
                cond_next  = (k_reg == '0) || (cur_reg <= nb);
                prod_next  = prod_full[PROB_W+15:16];
                nb_next    = nb;
                state_next = ST_WB;
            end
            ST_WB:
            begin
                ram_we     = 1'b1;
                state_next = ST_EX;
                if (k_reg != '0)
                begin
                    // next class down; prefetch its lower neighbor
                    k_next    = k_reg - AW'(1);
                    cur_next  = nb_reg;
                    ram_re    = (k_reg > AW'(1));
                    ram_raddr = k_reg - AW'(2);
                end
                else if (!frac_pass_reg && (({1'b0, top_reg} + (AW+1)'(1)) < whole))
                begin
                    // next whole pass, cleared top entry
                    top_next  = top_reg + AW'(1);
                    k_next    = top_reg + AW'(1);
                    cur_next  = PROB_ZERO;
                    ram_re    = 1'b1;
                    ram_raddr = top_reg;
                end
                else if (!frac_pass_reg && (frac != '0))
                begin
                    // extra pass with factor frac(n) * p
                    top_next       = whole[AW-1:0];
                    k_next         = whole[AW-1:0];
                    cur_next       = PROB_ZERO;
                    factor_next    = mul_reg[F+PROB_W-1:F];
                    frac_pass_next = 1'b1;
                    ram_re         = 1'b1;
                    ram_raddr      = whole[AW-1:0] - AW'(1);
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_ORD;
                end
                fwd_next      = ram_re && (ram_raddr == k_reg);
                fwd_data_next = wval;
            end
            ST_ORD:
            begin
                if (out_free)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_reg;
                    state_next = ST_OSH;
                end
            end
            ST_OSH:
            begin
                res_ctl.load = 1'b1;
                res_ctl.last = last_out;
                if (last_out)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_ORD;
                end
            end
            ST_EMIT:
            begin
                // empty table or single entry p * n
                res_index = '0;
                if (n_reg == '0)
                begin
                    res_prob  = PROB_ZERO;
                    res_total = '0;
                end
                else
                begin
                    res_prob  = mul_reg[F+PROB_W-1:F];
                    res_total = TW'(1);
                end
                if (out_free)
                begin
                    res_ctl.load     = 1'b1;
                    res_ctl.is_empty = (n_reg == '0);
                    res_ctl.last     = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            top_reg       <= '0;
            k_reg         <= '0;
            idx_reg       <= '0;
            frac_pass_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            k_reg         <= k_next;
            idx_reg       <= idx_next;
            frac_pass_reg <= frac_pass_next;
            fwd_reg       <= fwd_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        n_reg        <= n_next;
        mul_reg      <= mul_next;
        total_reg    <= total_next;
        factor_reg   <= factor_next;
        cur_reg      <= cur_next;
        nb_reg       <= nb_next;
        prod_reg     <= prod_next;
        cond_reg     <= cond_next;
        fwd_data_reg <= fwd_data_next;
    end

endmodule

// ===== hw/rtl/repetition_reach_distribution.sv =====
// Sequencing: a SETUP state, then an EX and a WB state per class update, and an ORD and
//   an OSH state per result word. Updates per item: sum of (j+1) over the whole passes j,
//   plus ceil(n) for a fractional pass. For n <= 1, SETUP goes straight to EMIT.
// Items: one at a time; the RAM read/update/write loop paces the updates.
// Reset: rst_n asynchronous, active low; clears control and output valid.
//   The class table is not cleared; every entry is written before it is read.
module repetition_reach_distribution #(
    parameter int unsigned MAX_CLASSES     = rrd_pkg::DEF_MAX_CLASSES,
    parameter int unsigned COUNT_FRAC_BITS = rrd_pkg::DEF_COUNT_FRAC_BITS
) (
    input  logic clk,
    input  logic rst_n,
    // trial_prob, trial_count
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [((rrd_pkg::PROB_W + $clog2(MAX_CLASSES) + 1 + COUNT_FRAC_BITS + 7) / 8) * 8 - 1:0]
                 s_axis_tdata,
    // class_index, class_prob, class_total
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [(($clog2(MAX_CLASSES) + rrd_pkg::PROB_W + $clog2(MAX_CLASSES + 1) + 7) / 8) * 8 - 1:0]
                 m_axis_tdata,
    output logic m_axis_tlast,
    // is_empty
    output logic m_axis_tuser
);

    import rrd_pkg::*;

    localparam int unsigned AW  = $clog2(MAX_CLASSES);
    localparam int unsigned TW  = $clog2(MAX_CLASSES + 1);
    localparam int unsigned CW  = AW + 1 + COUNT_FRAC_BITS;
    localparam int unsigned ODW = ((AW + PROB_W + TW + 7) / 8) * 8;
    localparam int unsigned PAD = ODW - (AW + PROB_W + TW);

    res_ctl_t           res_ctl;
    logic [AW-1:0]      res_index;
    logic [PROB_W-1:0]  res_prob;
    logic [TW-1:0]      res_total;
    logic               out_free;
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [PROB_W-1:0]  ram_wdata, ram_rdata;

    logic               out_valid_reg, out_valid_next;
    logic [ODW-1:0]     out_data_reg;
    logic               out_last_reg;
    logic               out_empty_reg;

    rrd_engine #(
        .MAX_CLASSES     (MAX_CLASSES),
        .COUNT_FRAC_BITS (COUNT_FRAC_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .trial_prob  (s_axis_tdata[PROB_W-1:0]),
        .trial_count (s_axis_tdata[PROB_W+CW-1:PROB_W]),
        .out_free    (out_free),
        .res_ctl     (res_ctl),
        .res_index   (res_index),
        .res_prob    (res_prob),
        .res_total   (res_total),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    rrd_ram #(
        .WIDTH (PROB_W),
        .DEPTH (MAX_CLASSES)
    ) u_class_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output word register
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ctl.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ctl.load)
        begin
            out_data_reg  <= {{PAD{1'b0}}, res_total, res_prob, res_index};
            out_last_reg  <= res_ctl.last;
            out_empty_reg <= res_ctl.is_empty;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_empty_reg;

endmodule

// ===== hw/rtl/rrd_checker.sv =====
// Port-level checks for repetition_reach_distribution, attached by bind.
// Depends on rrd_pkg and the top-level port list.
module rrd_checker #(
    parameter int unsigned MAX_CLASSES     = rrd_pkg::DEF_MAX_CLASSES,
    parameter int unsigned COUNT_FRAC_BITS = rrd_pkg::DEF_COUNT_FRAC_BITS
) (
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    // trial_prob, trial_count
    input logic [((rrd_pkg::PROB_W + $clog2(MAX_CLASSES) + 1 + COUNT_FRAC_BITS + 7) / 8) * 8 - 1:0]
                s_axis_tdata,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    // class_index, class_prob, class_total
    input logic [(($clog2(MAX_CLASSES) + rrd_pkg::PROB_W + $clog2(MAX_CLASSES + 1) + 7) / 8) * 8 - 1:0]
                m_axis_tdata,
    input logic m_axis_tlast,
    // is_empty
    input logic m_axis_tuser
);

    import rrd_pkg::*;

    localparam int unsigned AW = $clog2(MAX_CLASSES);
    localparam int unsigned TW = $clog2(MAX_CLASSES + 1);

    logic              in_acc, out_acc;
    logic [AW-1:0]     idx;
    logic [PROB_W-1:0] prob;
    logic [TW-1:0]     total;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign idx     = m_axis_tdata[AW-1:0];
    assign prob    = m_axis_tdata[AW+PROB_W-1:AW];
    assign total   = m_axis_tdata[AW+PROB_W+TW-1:AW+PROB_W];

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // one item at a time: no input taken right after one was accepted
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("input accepted back to back");

    // empty marker closes the run and carries zero total and zero probability
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && m_axis_tuser |-> m_axis_tlast && (total == '0) && (prob == '0))
        else $error("malformed empty result");

    // class index within the table and probability at most 1.0
    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && !m_axis_tuser |-> (TW'(idx) < total) && (prob <= PROB_ONE))
        else $error("class index or probability out of range");

    // last word of a run carries the final class
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && !m_axis_tuser && m_axis_tlast |-> (TW'(idx) + TW'(1)) == total)
        else $error("last word is not the final class");

endmodule

bind repetition_reach_distribution rrd_checker #(
    .MAX_CLASSES     (MAX_CLASSES),
    .COUNT_FRAC_BITS (COUNT_FRAC_BITS)
) u_rrd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
